@@ rtl/bcurve_pkg.sv @@
// ----------------------------------------------------------------------------
// bcurve_pkg
// Shared constants, curve ROM contents and register codes for the battery
// curve interpolator.
// ----------------------------------------------------------------------------
package bcurve_pkg;

  localparam int MV_W     = 13;
  localparam int PCT_W    = 7;
  localparam int SCALE_W  = 26;
  localparam int KEY_W    = 15;
  localparam int SLOTS    = 16;
  localparam int SLOT_W   = 4;
  localparam int RES_W    = 32;
  localparam int DEN_W    = 13;
  localparam int DIV_W    = RES_W + DEN_W;
  localparam int PT_W     = PCT_W + MV_W;

  localparam logic OP_PCT_FROM_MV = 1'b0;
  localparam logic OP_MV_FROM_PCT = 1'b1;
  localparam logic CURVE_DISCHARGE = 1'b0;

  typedef enum logic [0:0] {
    CFG_FULL_VOLTAGE = 1'b0,
    CFG_COMPENSATION = 1'b1
  } cfg_idx_t;

  // Each point is {percent, millivolts}. Slots past the thirteenth repeat
  // the last point of the curve.
  localparam logic [PT_W-1:0] CURVE_ROM [0:1][0:SLOTS-1] = '{
    '{ {7'd0, 13'd3300},  {7'd2, 13'd3490},  {7'd5, 13'd3615},
       {7'd10, 13'd3655}, {7'd20, 13'd3700}, {7'd30, 13'd3735},
       {7'd40, 13'd3760}, {7'd50, 13'd3800}, {7'd60, 13'd3855},
       {7'd70, 13'd3935}, {7'd80, 13'd4025}, {7'd90, 13'd4120},
       {7'd100, 13'd4230}, {7'd100, 13'd4230}, {7'd100, 13'd4230},
       {7'd100, 13'd4230} },
    '{ {7'd0, 13'd3550},  {7'd2, 13'd3570},  {7'd5, 13'd3600},
       {7'd10, 13'd3645}, {7'd20, 13'd3730}, {7'd30, 13'd3800},
       {7'd40, 13'd3860}, {7'd50, 13'd3915}, {7'd60, 13'd3970},
       {7'd70, 13'd4030}, {7'd80, 13'd4095}, {7'd90, 13'd4175},
       {7'd100, 13'd4260}, {7'd100, 13'd4260}, {7'd100, 13'd4260},
       {7'd100, 13'd4260} }
  };

  function automatic logic [MV_W-1:0] rom_mv(input logic sel,
                                             input logic [SLOT_W-1:0] i);
    return CURVE_ROM[sel][i][MV_W-1:0];
  endfunction

  function automatic logic [PCT_W-1:0] rom_pct(input logic sel,
                                               input logic [SLOT_W-1:0] i);
    return CURVE_ROM[sel][i][PT_W-1:MV_W];
  endfunction

endpackage

@@ rtl/bcurve_div.sv @@
// ----------------------------------------------------------------------------
// bcurve_div
// Restoring divider, one quotient bit per cycle. The dividend and divisor
// are captured on start; done pulses for one cycle when the quotient is
// ready and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module bcurve_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bcurve_pkg::DIV_W-1:0] dividend,
  input  logic [bcurve_pkg::DEN_W-1:0] divisor,
  output logic                       done,
  output logic [bcurve_pkg::DIV_W-1:0] quotient
);
  import bcurve_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= CNT_W'(DIV_W);
        den      <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        // The partial remainder stays below the divisor, so it fits DEN_W bits.
        if (fits) begin
          rem <= DEN_W'(trial - {1'b0, den});
        end else begin
          rem <= trial[DEN_W-1:0];
        end
        quotient <= {quotient[DIV_W-2:0], fits};
        count    <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/battery_curve_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// battery_curve_interpolator_top
// Piecewise-linear conversion between battery voltage and charge percent
// over a fixed charge or discharge curve, with a sequential segment search,
// one shared 32x13 multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Content
//  s_axis    in         s_axis_tvalid/s_axis_tready  lookup request
//  m_axis    out        m_axis_tvalid/m_axis_tready  result_value
//  cfg       in         cfg_valid/cfg_ready          register index and data
//
// Interpolated percents go S_CHECK, S_SEARCH, S_SEG, S_START, S_DPCT, S_MULC, S_DIV,
// S_FIN; voltages skip S_START and S_DPCT. The search visits one point per cycle,
// from the top segment down. Clamped percents go S_CHECK, S_START, S_FIN, a percent
// above the top S_CHECK, S_FIN; zero-width segments leave S_SEG for S_START or S_FIN.
// A request is taken only in idle; a result held by the receiver keeps the block in
// its final state. Reset is synchronous and restores the defaults.
// ----------------------------------------------------------------------------
module battery_curve_interpolator_top #(
  parameter int DISCHARGE_POINT_COUNT = 13,
  parameter int CHARGE_POINT_COUNT    = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: voltage_mv[12:0], percent_in[19:13], apply_compensation[20],
  //        scale_factor[46:21], zero[47]
  input  logic [47:0]           s_axis_tdata,
  // tuser: opcode[0], charging[1]
  input  logic [1:0]            s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: result_value[31:0]
  output logic [31:0]           m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  bcurve_pkg::cfg_idx_t  cfg_index,
  input  logic [12:0]           cfg_data
);
  import bcurve_pkg::*;

  localparam int ND = (DISCHARGE_POINT_COUNT < 2) ? 2 :
                      (DISCHARGE_POINT_COUNT > SLOTS) ? SLOTS : DISCHARGE_POINT_COUNT;
  localparam int NC = (CHARGE_POINT_COUNT < 2) ? 2 :
                      (CHARGE_POINT_COUNT > SLOTS) ? SLOTS : CHARGE_POINT_COUNT;
  localparam logic [SLOT_W-1:0] D_LAST = SLOT_W'(ND - 1);
  localparam logic [SLOT_W-1:0] C_LAST = SLOT_W'(NC - 1);
  localparam logic [MV_W-1:0]   D_BELOW1 = rom_mv(CURVE_DISCHARGE, SLOT_W'(ND - 2)) + 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SEARCH, S_SEG, S_START, S_DPCT, S_MULC, S_DIV, S_FIN
  } state_t;

  state_t               state;
  logic [MV_W-1:0]      full_voltage_mv;
  logic signed [MV_W-1:0] compensation_mv;

  logic                 opcode;
  logic                 charging;
  logic signed [KEY_W-1:0] key_mv;
  logic [PCT_W-1:0]     key_pct;
  logic [SCALE_W-1:0]   scale_factor;
  logic [SLOT_W-1:0]    idx;
  logic [MV_W-1:0]      lo_mv;
  logic [MV_W-1:0]      hi_mv;
  logic [PCT_W-1:0]     lo_pct;
  logic [PCT_W-1:0]     hi_pct;
  logic                 direct;
  logic [RES_W-1:0]     start_val;
  logic [RES_W-1:0]     dpct;
  logic [RES_W-1:0]     result_value;

  logic [MV_W-1:0]      disch_top;
  logic [SLOT_W-1:0]    last_idx;
  logic [SLOT_W-1:0]    next_idx;
  logic [MV_W-1:0]      mv_first, mv_last, mv_idx, mv_next;
  logic [PCT_W-1:0]     pct_first, pct_last, pct_idx, pct_next;
  logic signed [KEY_W-1:0] key_in;
  logic signed [KEY_W-1:0] dmv_full;
  logic [PCT_W-1:0]     pct_span;
  logic [RES_W-1:0]     mul_a;
  logic [DEN_W-1:0]     mul_b;
  logic [DIV_W-1:0]     mul_prod;
  logic                 div_start;
  logic [DEN_W-1:0]     div_den;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quot;
  logic                 keep_going;

  // The top discharge point is never allowed to sit at or below its neighbor.
  function automatic logic [MV_W-1:0] pt_mv(input logic sel,
                                            input logic [SLOT_W-1:0] i,
                                            input logic [MV_W-1:0] top);
    logic [MV_W-1:0] v;
    v = rom_mv(sel, i);
    if (sel == CURVE_DISCHARGE && i == D_LAST) begin
      v = top;
    end
    return v;
  endfunction

  assign disch_top = (full_voltage_mv > D_BELOW1) ? full_voltage_mv : D_BELOW1;
  assign last_idx  = (charging == CURVE_DISCHARGE) ? D_LAST : C_LAST;
  assign next_idx  = idx + 1'b1;

  assign mv_first  = pt_mv(charging, '0, disch_top);
  assign mv_last   = pt_mv(charging, last_idx, disch_top);
  assign mv_idx    = pt_mv(charging, idx, disch_top);
  assign mv_next   = pt_mv(charging, next_idx, disch_top);
  assign pct_first = rom_pct(charging, '0);
  assign pct_last  = rom_pct(charging, last_idx);
  assign pct_idx   = rom_pct(charging, idx);
  assign pct_next  = rom_pct(charging, next_idx);

  assign key_in = $signed({2'b00, s_axis_tdata[12:0]}) +
                  (s_axis_tdata[20] ? KEY_W'(compensation_mv) : KEY_W'(0));

  assign dmv_full = key_mv - $signed({2'b00, lo_mv});
  assign pct_span = hi_pct - lo_pct;

  assign keep_going = (idx != '0) &&
                      ((opcode == OP_PCT_FROM_MV) ? (key_mv < $signed({2'b00, mv_idx}))
                                                  : (key_pct < pct_idx));

  // Shared multiplier: start percent, percent span and interpolation product.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_START: begin
        mul_a = RES_W'(scale_factor);
        mul_b = DEN_W'(lo_pct);
      end
      S_DPCT: begin
        mul_a = RES_W'(scale_factor);
        mul_b = DEN_W'(pct_span);
      end
      S_MULC: begin
        if (opcode == OP_PCT_FROM_MV) begin
          mul_a = dpct;
          mul_b = dmv_full[DEN_W-1:0];
        end else begin
          mul_a = RES_W'(key_pct - lo_pct);
          mul_b = hi_mv - lo_mv;
        end
      end
      default: begin
      end
    endcase
  end

  assign mul_prod  = {{(DIV_W-RES_W){1'b0}}, mul_a} * {{(DIV_W-DEN_W){1'b0}}, mul_b};
  assign div_start = (state == S_MULC);
  assign div_den   = (opcode == OP_PCT_FROM_MV) ? (hi_mv - lo_mv) : DEN_W'(pct_span);

  bcurve_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
      full_voltage_mv <= 13'd4230;
      compensation_mv <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FULL_VOLTAGE: full_voltage_mv <= cfg_data;
          CFG_COMPENSATION: compensation_mv <= $signed(cfg_data);
        endcase
      end

      // The output register loads from the final state whenever it is free.
      if (state == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tdata  <= result_value;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            opcode       <= s_axis_tuser[0];
            charging     <= s_axis_tuser[1];
            key_mv       <= key_in;
            key_pct      <= s_axis_tdata[19:13];
            scale_factor <= s_axis_tdata[46:21];
            state        <= S_CHECK;
          end
        end
        S_CHECK: begin
          direct <= 1'b1;
          idx    <= last_idx - 1'b1;
          if (opcode == OP_PCT_FROM_MV) begin
            if (key_mv <= $signed({2'b00, mv_first})) begin
              lo_pct <= pct_first;
              state  <= S_START;
            end else if (key_mv >= $signed({2'b00, mv_last})) begin
              lo_pct <= pct_last;
              state  <= S_START;
            end else begin
              state <= S_SEARCH;
            end
          end else if (key_pct > pct_last) begin
            result_value <= RES_W'(mv_last);
            state        <= S_FIN;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (keep_going) begin
            idx <= idx - 1'b1;
          end else begin
            state <= S_SEG;
          end
        end
        S_SEG: begin
          lo_mv  <= mv_idx;
          hi_mv  <= mv_next;
          lo_pct <= pct_idx;
          hi_pct <= pct_next;
          if (opcode == OP_PCT_FROM_MV) begin
            direct <= (mv_next == mv_idx);
            state  <= S_START;
          end else if (pct_next == pct_idx) begin
            result_value <= RES_W'(mv_next);
            state        <= S_FIN;
          end else begin
            state <= S_MULC;
          end
        end
        S_START: begin
          start_val <= mul_prod[RES_W-1:0];
          if (direct) begin
            result_value <= mul_prod[RES_W-1:0];
            state        <= S_FIN;
          end else begin
            state <= S_DPCT;
          end
        end
        S_DPCT: begin
          dpct  <= mul_prod[RES_W-1:0];
          state <= S_MULC;
        end
        S_MULC: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (opcode == OP_PCT_FROM_MV) begin
              result_value <= div_quot[RES_W-1:0] + start_val;
            end else begin
              result_value <= RES_W'(lo_mv) + div_quot[RES_W-1:0];
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
